// File: sv/mts_pkg.sv
// Shared types and constants for the min-tracking stack.
`timescale 1ns / 1ps

package mts_pkg;

    localparam int FIELD_BITS = 32;
    localparam int DEPTH_BITS = 9;

    typedef enum logic {
        OP_PUSH = 1'b0,
        OP_POP  = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        STAT_DONE       = 2'd0,
        STAT_POP_EMPTY  = 2'd1,
        STAT_PUSH_FULL  = 2'd2
    } t_status;

    typedef enum logic {
        S_IDLE,
        S_POP_WAIT
    } t_state;

endpackage

// File: sv/mts_if.sv
// Valid/ready channel interfaces for the min-tracking stack.
`timescale 1ns / 1ps

interface mts_in_if;
    logic                                   valid;
    logic                                   ready;
    mts_pkg::t_op                           op;
    logic signed [mts_pkg::FIELD_BITS-1:0]  value;

    modport source (output valid, output op, output value, input ready);
    modport sink   (input valid, input op, input value, output ready);
endinterface

interface mts_out_if;
    logic                                   valid;
    logic                                   ready;
    mts_pkg::t_status                       status;
    logic signed [mts_pkg::FIELD_BITS-1:0]  popped;
    logic signed [mts_pkg::FIELD_BITS-1:0]  top_value;
    logic signed [mts_pkg::FIELD_BITS-1:0]  min_value;
    logic        [mts_pkg::DEPTH_BITS-1:0]  depth;
    logic                                   is_empty;

    modport source (output valid, output status, output popped, output top_value,
                    output min_value, output depth, output is_empty, input ready);
    modport sink   (input valid, input status, input popped, input top_value,
                    input min_value, input depth, input is_empty, output ready);
endinterface

// File: sv/min_tracking_stack_unit.sv
// Min-tracking stack: entry and running-minimum stacks in RAM, tops cached in registers.
`timescale 1ns / 1ps

// Each transfer on i_in is a push or a pop and yields one transfer on o_out with the status,
// the popped word, the new top, the new minimum and the depth. A push is settled by the
// cached top and minimum registers and its RAM writes go out at once. A pop goes
// through S_POP_WAIT, since the entry below the top and the minimum below it come back
// from the registered reads of the two RAMs. The result sits in a registered output
// stage; while it waits i_in is held off, and the next transfer is taken in the cycle the
// waiting result leaves. No clearing pass after reset; the stack counts guard every RAM
// read.

module min_tracking_stack_unit #(
    parameter int STACK_DEPTH = 256,
    parameter int WORD_BITS   = 32
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    mts_in_if.sink       i_in,
    mts_out_if.source    o_out
);

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam logic [WORD_BITS-1:0] WORD_ONES = '1;

    mts_pkg::t_state  r_state, n_state;
    logic [CW-1:0]         r_cnt, n_cnt;
    logic [CW-1:0]         r_mcnt, n_mcnt;
    logic [WORD_BITS-1:0]  r_top, n_top;
    logic [WORD_BITS-1:0]  r_min, n_min;
    logic [WORD_BITS-1:0]  r_popped, n_popped;
    logic                  r_min_dec, n_min_dec;

    logic                                   r_ovalid;
    mts_pkg::t_status                       r_status;
    logic [mts_pkg::FIELD_BITS-1:0]         r_out_popped, r_out_top, r_out_min;
    logic [mts_pkg::DEPTH_BITS-1:0]         r_out_depth;
    logic                                   r_out_empty;

    logic                  in_ready, fire, load_out;
    mts_pkg::t_status      out_status;
    logic [WORD_BITS-1:0]  out_popped, in_word;
    logic                  take_min;

    logic                  ent_we, min_we;
    logic [AW-1:0]         ent_waddr, min_waddr, ent_raddr, min_raddr;
    logic [WORD_BITS-1:0]  ent_rdata, min_rdata;

    mts_ram #(.WIDTH(WORD_BITS), .DEPTH(STACK_DEPTH)) u_entry_ram (
        .i_clk   (i_clk),
        .i_we    (ent_we),
        .i_waddr (ent_waddr),
        .i_wdata (in_word),
        .i_raddr (ent_raddr),
        .o_rdata (ent_rdata)
    );

    mts_ram #(.WIDTH(WORD_BITS), .DEPTH(STACK_DEPTH)) u_min_ram (
        .i_clk   (i_clk),
        .i_we    (min_we),
        .i_waddr (min_waddr),
        .i_wdata (in_word),
        .i_raddr (min_raddr),
        .o_rdata (min_rdata)
    );

    assign in_word   = WORD_BITS'($unsigned(i_in.value));
    assign in_ready  = (r_state == mts_pkg::S_IDLE) && (!r_ovalid || o_out.ready);
    assign fire      = i_in.valid && in_ready;
    assign ent_waddr = AW'(r_cnt);
    assign min_waddr = AW'(r_mcnt);
    assign ent_raddr = AW'(r_cnt - CW'(2));
    assign min_raddr = AW'(r_mcnt - CW'(2));
    assign take_min  = (r_mcnt == '0) || ($signed(in_word) <= $signed(r_min));

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_mcnt     = r_mcnt;
        n_top      = r_top;
        n_min      = r_min;
        n_popped   = r_popped;
        n_min_dec  = r_min_dec;
        ent_we     = 1'b0;
        min_we     = 1'b0;
        load_out   = 1'b0;
        out_status = mts_pkg::STAT_DONE;
        out_popped = WORD_ONES;
        case (r_state)
            mts_pkg::S_IDLE: begin
                if (fire) begin
                    if (i_in.op == mts_pkg::OP_PUSH) begin
                        load_out = 1'b1;
                        if (r_cnt == CW'(STACK_DEPTH)) begin
                            out_status = mts_pkg::STAT_PUSH_FULL;
                        end else begin
                            ent_we = 1'b1;
                            n_cnt  = r_cnt + CW'(1);
                            n_top  = in_word;
                            if (take_min && r_mcnt != CW'(STACK_DEPTH)) begin
                                min_we = 1'b1;
                                n_mcnt = r_mcnt + CW'(1);
                                n_min  = in_word;
                            end
                        end
                    end else if (r_cnt == '0) begin
                        load_out   = 1'b1;
                        out_status = mts_pkg::STAT_POP_EMPTY;
                    end else begin
                        n_cnt     = r_cnt - CW'(1);
                        n_popped  = r_top;
                        n_min_dec = (r_mcnt != '0) && (r_min == r_top);
                        if (n_min_dec) begin
                            n_mcnt = r_mcnt - CW'(1);
                        end
                        n_state = mts_pkg::S_POP_WAIT;
                    end
                end
            end
            mts_pkg::S_POP_WAIT: begin
                if (r_cnt != '0) begin
                    n_top = ent_rdata;
                end
                if (r_min_dec && r_mcnt != '0) begin
                    n_min = min_rdata;
                end
                load_out   = 1'b1;
                out_popped = r_popped;
                n_state    = mts_pkg::S_IDLE;
            end
            default: begin
                n_state = mts_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= mts_pkg::S_IDLE;
            r_cnt    <= '0;
            r_mcnt   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_mcnt  <= n_mcnt;
            if (load_out) begin
                r_ovalid <= 1'b1;
            end else if (o_out.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_top     <= n_top;
        r_min     <= n_min;
        r_popped  <= n_popped;
        r_min_dec <= n_min_dec;
        if (load_out) begin
            r_status     <= out_status;
            r_out_popped <= mts_pkg::FIELD_BITS'(out_popped);
            r_out_top    <= mts_pkg::FIELD_BITS'((n_cnt != '0) ? n_top : WORD_ONES);
            r_out_min    <= mts_pkg::FIELD_BITS'(((n_cnt != '0) && (n_mcnt != '0))
                                                 ? n_min : WORD_ONES);
            r_out_depth  <= mts_pkg::DEPTH_BITS'(n_cnt);
            r_out_empty  <= (n_cnt == '0);
        end
    end

    assign i_in.ready      = in_ready;
    assign o_out.valid     = r_ovalid;
    assign o_out.status    = r_status;
    assign o_out.popped    = $signed(r_out_popped);
    assign o_out.top_value = $signed(r_out_top);
    assign o_out.min_value = $signed(r_out_min);
    assign o_out.depth     = r_out_depth;
    assign o_out.is_empty  = r_out_empty;

endmodule

// File: sv/mts_ram.sv
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps

module mts_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: verif/min_tracking_stack_unit_tb.sv
// Testbench for min_tracking_stack_unit: directed and random push/pop traffic checked against a shadow stack.
`timescale 1ns / 1ps

module min_tracking_stack_unit_tb;

    localparam int STACK_DEPTH = 256;
    localparam int WATCHDOG_LIMIT = 2000;

    typedef struct {
        mts_pkg::t_op                            op;
        logic signed [mts_pkg::FIELD_BITS-1:0]   value;
    } t_stack_cmd;

    typedef struct {
        mts_pkg::t_status                        status;
        logic signed [mts_pkg::FIELD_BITS-1:0]   popped;
        logic signed [mts_pkg::FIELD_BITS-1:0]   top_value;
        logic signed [mts_pkg::FIELD_BITS-1:0]   min_value;
        logic        [mts_pkg::DEPTH_BITS-1:0]   depth;
        logic                                    is_empty;
    } t_stack_reply;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    mts_in_if  in_ch ();
    mts_out_if out_ch ();

    min_tracking_stack_unit #(
        .STACK_DEPTH (STACK_DEPTH),
        .WORD_BITS   (mts_pkg::FIELD_BITS)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    always #1 i_clk = ~i_clk;

    // Shadow copy of the two stacks
    logic signed [mts_pkg::FIELD_BITS-1:0] shadow_entries [STACK_DEPTH];
    logic signed [mts_pkg::FIELD_BITS-1:0] shadow_mins    [STACK_DEPTH];
    int unsigned                  shadow_count;
    int unsigned                  shadow_min_count;

    t_stack_cmd   pending_cmds[$];
    t_stack_reply awaited_replies[$];
    t_stack_cmd   next_cmd;

    int unsigned total_cmds;
    int unsigned cmds_sent;
    int unsigned replies_seen;
    int unsigned mismatches;
    int unsigned quiet_cycles;
    int unsigned gen_depth;
    int unsigned n_push, n_pop, n_full_push, n_empty_pop, n_min_repeat, deepest;
    logic        in_taken;

    function automatic t_stack_reply apply_stack_cmd(mts_pkg::t_op op,
                                                     logic signed [mts_pkg::FIELD_BITS-1:0] v);
        t_stack_reply r;
        r.status = mts_pkg::STAT_DONE;
        r.popped = -1;
        if (op == mts_pkg::OP_PUSH) begin
            n_push++;
            if (shadow_count >= STACK_DEPTH) begin
                r.status = mts_pkg::STAT_PUSH_FULL;
                n_full_push++;
            end else begin
                if (shadow_min_count == 0 || v <= shadow_mins[shadow_min_count-1]) begin
                    if (shadow_min_count > 0 && v == shadow_mins[shadow_min_count-1])
                        n_min_repeat++;
                    if (shadow_min_count < STACK_DEPTH) begin
                        shadow_mins[shadow_min_count] = v;
                        shadow_min_count++;
                    end
                end
                shadow_entries[shadow_count] = v;
                shadow_count++;
            end
        end else begin
            n_pop++;
            if (shadow_count == 0) begin
                r.status = mts_pkg::STAT_POP_EMPTY;
                n_empty_pop++;
            end else begin
                shadow_count--;
                r.popped = shadow_entries[shadow_count];
                if (shadow_min_count > 0 && shadow_mins[shadow_min_count-1] == r.popped)
                    shadow_min_count--;
            end
        end
        if (shadow_count > deepest)
            deepest = shadow_count;
        r.top_value = (shadow_count != 0) ? shadow_entries[shadow_count-1] : -1;
        r.min_value = (shadow_count != 0 && shadow_min_count != 0)
                      ? shadow_mins[shadow_min_count-1] : -1;
        r.depth = shadow_count[mts_pkg::DEPTH_BITS-1:0];
        r.is_empty = (shadow_count == 0);
        return r;
    endfunction

    function automatic logic signed [mts_pkg::FIELD_BITS-1:0] pick_value();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: pick_value = $signed($urandom_range(0, 8)) - 4;
            4: begin
                case ($urandom_range(0, 3))
                    0: pick_value = 32'sh7fffffff;
                    1: pick_value = 32'sh80000000;
                    2: pick_value = 0;
                    default: pick_value = -1;
                endcase
            end
            default: pick_value = $urandom;
        endcase
    endfunction

    task automatic add_cmd(mts_pkg::t_op op, logic signed [mts_pkg::FIELD_BITS-1:0] v);
        t_stack_cmd c;
        c.op = op;
        c.value = v;
        pending_cmds.push_back(c);
        if (op == mts_pkg::OP_PUSH && gen_depth < STACK_DEPTH)
            gen_depth++;
        else if (op == mts_pkg::OP_POP && gen_depth > 0)
            gen_depth--;
    endtask

    task automatic add_walk(int unsigned n, int unsigned push_pct);
        for (int unsigned k = 0; k < n; k++) begin
            if ($urandom_range(0, 99) < push_pct)
                add_cmd(mts_pkg::OP_PUSH, pick_value());
            else
                add_cmd(mts_pkg::OP_POP, $urandom);
        end
    endtask

    // Fill to the top and push past it, then drain and pop past the bottom
    task automatic add_fill_drain();
        while (gen_depth < STACK_DEPTH) begin
            if (gen_depth > 0 && $urandom_range(0, 9) == 0)
                add_cmd(mts_pkg::OP_POP, $urandom);
            else
                add_cmd(mts_pkg::OP_PUSH, pick_value());
        end
        repeat ($urandom_range(2, 4)) add_cmd(mts_pkg::OP_PUSH, pick_value());
        while (gen_depth > 0) begin
            if ($urandom_range(0, 9) == 0)
                add_cmd(mts_pkg::OP_PUSH, pick_value());
            else
                add_cmd(mts_pkg::OP_POP, $urandom);
        end
        repeat ($urandom_range(2, 4)) add_cmd(mts_pkg::OP_POP, $urandom);
    endtask

    function automatic int unsigned sender_idle_pct();
        if (cmds_sent < total_cmds / 3)
            return 8;
        else if (cmds_sent < 2 * total_cmds / 3)
            return 60;
        return 0;
    endfunction

    function automatic int unsigned receiver_idle_pct();
        if (cmds_sent < total_cmds / 3)
            return 60;
        else if (cmds_sent < 2 * total_cmds / 3)
            return 8;
        return 0;
    endfunction

    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!in_ch.valid || in_taken) begin
                if (pending_cmds.size() > 0 && $urandom_range(0, 99) >= sender_idle_pct()) begin
                    next_cmd = pending_cmds.pop_front();
                    in_ch.valid <= 1'b1;
                    in_ch.op <= next_cmd.op;
                    in_ch.value <= next_cmd.value;
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
            out_ch.ready <= ($urandom_range(0, 99) >= receiver_idle_pct());
        end
    end

    always @(posedge i_clk) begin
        t_stack_reply want;
        t_stack_reply got;
        in_taken = 1'b0;
        if (i_rst_n) begin
            quiet_cycles++;
            if (in_ch.valid && in_ch.ready) begin
                in_taken = 1'b1;
                awaited_replies.push_back(apply_stack_cmd(in_ch.op, in_ch.value));
                cmds_sent++;
                quiet_cycles = 0;
            end
            if (out_ch.valid && out_ch.ready) begin
                quiet_cycles = 0;
                replies_seen++;
                got.status = out_ch.status;
                got.popped = out_ch.popped;
                got.top_value = out_ch.top_value;
                got.min_value = out_ch.min_value;
                got.depth = out_ch.depth;
                got.is_empty = out_ch.is_empty;
                if (awaited_replies.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: unexpected result transfer %p", $realtime, got);
                end else begin
                    want = awaited_replies.pop_front();
                    if (got.status !== want.status || got.popped !== want.popped ||
                        got.top_value !== want.top_value || got.min_value !== want.min_value ||
                        got.depth !== want.depth || got.is_empty !== want.is_empty) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("%0t: result %0d mismatch", $realtime, replies_seen);
                            $display("  expected %p", want);
                            $display("  actual   %p", got);
                        end
                    end
                end
            end
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no transfer for %0d cycles", $realtime, quiet_cycles);
                $display("tb: failure");
                $finish;
            end
        end
    end

    initial begin
        in_ch.valid = 1'b0;
        in_ch.op = mts_pkg::OP_PUSH;
        in_ch.value = '0;
        out_ch.ready = 1'b0;
        in_taken = 1'b0;
        shadow_count = 0;
        shadow_min_count = 0;
        gen_depth = 0;
        cmds_sent = 0;
        replies_seen = 0;
        mismatches = 0;
        quiet_cycles = 0;
        n_push = 0;
        n_pop = 0;
        n_full_push = 0;
        n_empty_pop = 0;
        n_min_repeat = 0;
        deepest = 0;

        // directed: empty pop, repeated minimum, word extremes
        add_cmd(mts_pkg::OP_POP, 0);
        add_cmd(mts_pkg::OP_PUSH, 5);
        add_cmd(mts_pkg::OP_PUSH, 7);
        add_cmd(mts_pkg::OP_PUSH, 5);
        add_cmd(mts_pkg::OP_PUSH, 3);
        repeat (4) add_cmd(mts_pkg::OP_POP, 0);
        add_cmd(mts_pkg::OP_POP, 32'sh7fffffff);
        add_cmd(mts_pkg::OP_PUSH, 32'sh7fffffff);
        add_cmd(mts_pkg::OP_PUSH, 32'sh80000000);
        add_cmd(mts_pkg::OP_PUSH, -1);
        add_cmd(mts_pkg::OP_PUSH, 0);
        add_cmd(mts_pkg::OP_PUSH, 32'sh80000000);
        add_cmd(mts_pkg::OP_PUSH, 32'sh7fffffff);
        repeat (6) add_cmd(mts_pkg::OP_POP, -1);
        add_cmd(mts_pkg::OP_POP, 32'sh80000000);

        add_walk(150, 60);
        add_fill_drain();
        add_walk(120, 40);
        add_walk(120, 75);
        add_walk(60, 20);
        add_fill_drain();
        while (pending_cmds.size() < 1550)
            add_walk($urandom_range(20, 80), $urandom_range(15, 85));
        total_cmds = pending_cmds.size();

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        while (cmds_sent < total_cmds || awaited_replies.size() != 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        $display("Ran %0d push/pop transfers (%0d pushes, %0d pops), peak depth %0d.",
                 cmds_sent, n_push, n_pop, deepest);
        $display("Rejected: %0d pushes on full, %0d pops on empty; %0d repeated-minimum pushes.",
                 n_full_push, n_empty_pop, n_min_repeat);
        if (mismatches == 0 && awaited_replies.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// File: min_tracking_stack_unit.f
sv/mts_pkg.sv
sv/mts_if.sv
sv/mts_ram.sv
sv/min_tracking_stack_unit.sv
verif/min_tracking_stack_unit_tb.sv
